// File: src/fos_pkg.sv
// shared constants, codes and record types for the framed operand stack
// no dependencies; imported by every module of the block
`default_nettype none

package fos_pkg;

  localparam int STACK_WORDS = 1024;
  localparam int MAX_FRAMES  = 64;

  localparam int ADDR_W   = $clog2(STACK_WORDS);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int FIDX_W   = $clog2(MAX_FRAMES);
  localparam int LVL_W    = FIDX_W + 1;

  localparam int WORD_W   = 32;
  localparam int LIMIT_W  = 11;
  localparam int ARG_W    = 16;
  localparam int PC_W     = 16;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 11;
  localparam int LEVEL_W  = 7;

  localparam int SUM_W    = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam int AF_W     = (ARG_W > CNT_W) ? ARG_W : CNT_W;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_CALL = 2'd2,
    OP_RET  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_NO_FRAME  = 3'd3,
    ST_NO_SPACE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] fill;
    logic [ARG_W-1:0] args;
    logic [PC_W-1:0]  pc;
  } frame_rec_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } word_req_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [FIDX_W-1:0] addr;
    frame_rec_t        wdata;
  } frame_req_t;

endpackage

`default_nettype wire

// File: src/framed_operand_stack.sv
// top level of the framed operand stack: sequencer plus word and frame stores
// depends on fos_pkg, fos_ctrl, fos_word_mem, fos_frame_mem
//
//   channel  handshake             payload
//   in       in_valid / in_stall   operation value frame_limit arg_count saved_pc
//   out      out_valid / out_stall status top_value depth frame_level current_pc
//
// an operation passes through accept, with reads of word and caller record, then
// execute with write-back; a return whose word does not fit a non-empty caller
// adds a fetch and a load state for a word read to recover the caller's top.
// rst is synchronous and closes all frames; store contents are not cleared.
// a result waits in the output register under out_stall while the next beat is
// accepted; execution holds until that register frees.
`default_nettype none

module framed_operand_stack import fos_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic signed [WORD_W-1:0]    value,
  input  logic [LIMIT_W-1:0]          frame_limit,
  input  logic [ARG_W-1:0]            arg_count,
  input  logic [PC_W-1:0]             saved_pc,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic signed [WORD_W-1:0]    top_value,
  output logic [DEPTH_W-1:0]          depth,
  output logic [LEVEL_W-1:0]          frame_level,
  output logic [PC_W-1:0]             current_pc
);

  word_req_t         word_req;
  logic [WORD_W-1:0] word_rdata;
  frame_req_t        frame_req;
  frame_rec_t        frame_rdata;
  logic [WORD_W-1:0] top_bits;

  assign top_value = top_bits;

  fos_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .frame_limit (frame_limit),
    .arg_count   (arg_count),
    .saved_pc    (saved_pc),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .top_value   (top_bits),
    .depth       (depth),
    .frame_level (frame_level),
    .current_pc  (current_pc),
    .word_req    (word_req),
    .word_rdata  (word_rdata),
    .frame_req   (frame_req),
    .frame_rdata (frame_rdata)
  );

  fos_word_mem u_word_mem (
    .clk   (clk),
    .req   (word_req),
    .rdata (word_rdata)
  );

  fos_frame_mem u_frame_mem (
    .clk   (clk),
    .req   (frame_req),
    .rdata (frame_rdata)
  );

endmodule

`default_nettype wire

// File: src/fos_word_mem.sv
// single-port word store shared by all frames, registered read data
// depends on fos_pkg
`default_nettype none

module fos_word_mem import fos_pkg::*; (
  input  logic              clk,
  input  word_req_t         req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [STACK_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// File: src/fos_frame_mem.sv
// single-port store of suspended caller frame records, registered read data
// depends on fos_pkg
`default_nettype none

module fos_frame_mem import fos_pkg::*; (
  input  logic       clk,
  input  frame_req_t req,
  output frame_rec_t rdata
);

  frame_rec_t mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// File: src/fos_ctrl.sv
// sequencer: holds the open frame record and top word in registers,
// drives both memories and the result register; depends on fos_pkg
`default_nettype none

module fos_ctrl import fos_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [WORD_W-1:0]    value,
  input  logic [LIMIT_W-1:0]   frame_limit,
  input  logic [ARG_W-1:0]     arg_count,
  input  logic [PC_W-1:0]      saved_pc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [WORD_W-1:0]    top_value,
  output logic [DEPTH_W-1:0]   depth,
  output logic [LEVEL_W-1:0]   frame_level,
  output logic [PC_W-1:0]      current_pc,
  output word_req_t            word_req,
  input  logic [WORD_W-1:0]    word_rdata,
  output frame_req_t           frame_req,
  input  frame_rec_t           frame_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FETCH, S_LOAD} state_t;

  state_t             state, state_next;
  op_t                op_q;
  logic [WORD_W-1:0]  value_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [ARG_W-1:0]   args_q;
  logic [PC_W-1:0]    pc_q;

  frame_rec_t         cur, cur_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [WORD_W-1:0]  top, top_next;

  logic               out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [WORD_W-1:0]  top_value_next;
  logic [DEPTH_W-1:0] depth_next;
  logic [LEVEL_W-1:0] frame_level_next;
  logic [PC_W-1:0]    current_pc_next;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic [CNT_W-1:0]   new_base;
  logic               space_bad;
  logic [CNT_W-1:0]   ret_fill;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // the new frame sits right after the caller's reserved region
  assign new_base  = (lvl == '0) ? '0 : cur.base + cur.cap;
  assign space_bad = (SUM_W'(limit_q) + SUM_W'(new_base)) > SUM_W'(STACK_WORDS);

  // caller fill after argument removal, clamped at empty
  assign ret_fill = (AF_W'(cur.args) > AF_W'(frame_rdata.fill)) ? '0
                  : frame_rdata.fill - CNT_W'(cur.args);

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    lvl_next         = lvl;
    top_next         = top;
    word_req         = '0;
    frame_req        = '0;
    load_out         = 1'b0;
    status_next      = status;
    out_valid_next   = out_valid && out_stall;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // speculative reads: word below the top for pop, caller record for return
          word_req.rd    = 1'b1;
          word_req.addr  = ADDR_W'(cur.base + cur.fill - CNT_W'(2));
          frame_req.rd   = 1'b1;
          frame_req.addr = FIDX_W'(lvl - LVL_W'(2));
          state_next     = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          load_out    = 1'b1;
          state_next  = S_IDLE;
          status_next = ST_OK;
          case (op_q)
            OP_CALL: begin
              if (lvl >= LVL_W'(MAX_FRAMES) || space_bad) begin
                status_next = ST_NO_SPACE;
              end else begin
                if (lvl != '0) begin
                  frame_req.wr    = 1'b1;
                  frame_req.addr  = FIDX_W'(lvl - LVL_W'(1));
                  frame_req.wdata = cur;
                end
                cur_next.base = new_base;
                cur_next.cap  = CNT_W'(limit_q);
                cur_next.fill = '0;
                cur_next.args = args_q;
                cur_next.pc   = pc_q;
                lvl_next      = lvl + LVL_W'(1);
                top_next      = '0;
              end
            end
            OP_PUSH: begin
              if (lvl == '0) begin
                status_next = ST_NO_FRAME;
              end else if (cur.fill >= cur.cap) begin
                status_next = ST_OVERFLOW;
              end else begin
                word_req.wr    = 1'b1;
                word_req.addr  = ADDR_W'(cur.base + cur.fill);
                word_req.wdata = value_q;
                cur_next.fill  = cur.fill + CNT_W'(1);
                top_next       = value_q;
              end
            end
            OP_POP: begin
              if (lvl == '0) begin
                status_next = ST_NO_FRAME;
              end else if (cur.fill == '0) begin
                status_next = ST_UNDERFLOW;
              end else begin
                cur_next.fill = cur.fill - CNT_W'(1);
                top_next      = (cur.fill != CNT_W'(1)) ? word_rdata : '0;
              end
            end
            OP_RET: begin
              if (lvl == '0) begin
                status_next = ST_NO_FRAME;
              end else begin
                lvl_next = lvl - LVL_W'(1);
                if (lvl == LVL_W'(1)) begin
                  top_next = '0;
                end else begin
                  cur_next      = frame_rdata;
                  cur_next.fill = ret_fill;
                  if (ret_fill < frame_rdata.cap) begin
                    word_req.wr    = 1'b1;
                    word_req.addr  = ADDR_W'(frame_rdata.base + ret_fill);
                    word_req.wdata = top;
                    cur_next.fill  = ret_fill + CNT_W'(1);
                  end else begin
                    // returned word dropped, caller top must come from memory unless the caller is empty
                    status_next = ST_OVERFLOW;
                    if (ret_fill != '0) begin
                      load_out   = 1'b0;
                      state_next = S_FETCH;
                    end else begin
                      top_next = '0;
                    end
                  end
                end
              end
            end
          endcase
        end
      end

      S_FETCH: begin
        word_req.rd   = 1'b1;
        word_req.addr = ADDR_W'(cur.base + cur.fill - CNT_W'(1));
        state_next    = S_LOAD;
      end

      S_LOAD: begin
        top_next   = word_rdata;
        load_out   = 1'b1;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    top_value_next   = top_value;
    depth_next       = depth;
    frame_level_next = frame_level;
    current_pc_next  = current_pc;
    if (load_out) begin
      out_valid_next   = 1'b1;
      frame_level_next = LEVEL_W'(lvl_next);
      if (lvl_next != '0) begin
        top_value_next  = top_next;
        depth_next      = DEPTH_W'(cur_next.fill);
        current_pc_next = cur_next.pc;
      end else begin
        top_value_next  = '0;
        depth_next      = '0;
        current_pc_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      out_valid <= out_valid_next;
    end
    if (accept) begin
      op_q    <= op_t'(operation);
      value_q <= value;
      limit_q <= frame_limit;
      args_q  <= arg_count;
      pc_q    <= saved_pc;
    end
    cur         <= cur_next;
    top         <= top_next;
    status      <= status_next;
    top_value   <= top_value_next;
    depth       <= depth_next;
    frame_level <= frame_level_next;
    current_pc  <= current_pc_next;
  end

endmodule

`default_nettype wire
